// File: design/tcce_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the text console character engine.
// No dependencies.
package tcce_pkg;

   localparam int MAX_COLUMNS_DEF = 80;
   localparam int MAX_LINES_DEF   = 25;
   localparam int TAB_STOP_DEF    = 8;

   localparam int COL_W  = 7;
   localparam int LINE_W = 5;
   localparam int HW_W   = 12;
   localparam int CELL_W = 16;
   localparam int CLR_W  = 4;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [COL_W-1:0]  COLUMN_COUNT_RST = 7'd80;
   localparam logic [LINE_W-1:0] LINE_COUNT_RST   = 5'd25;
   localparam logic [CLR_W-1:0]  FOREGROUND_RST   = 4'd15;
   localparam logic [CLR_W-1:0]  BACKGROUND_RST   = 4'd0;

   localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] REG_LINE_COUNT   = 2'd1;
   localparam logic [1:0] REG_FOREGROUND   = 2'd2;
   localparam logic [1:0] REG_BACKGROUND   = 2'd3;

   localparam logic [1:0] OP_CHAR   = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_SET    = 2'd2;
   localparam logic [1:0] OP_SCROLL = 2'd3;

   localparam logic [7:0] CH_PRINT_LO = 8'd32;
   localparam logic [7:0] CH_PRINT_HI = 8'd126;
   localparam logic [7:0] CH_BS       = 8'd8;
   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_LF       = 8'd10;
   localparam logic [7:0] CH_FF       = 8'd12;
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_SPACE    = 8'h20;

   typedef struct packed {
      logic [COL_W-1:0]  column_count;
      logic [LINE_W-1:0] line_count;
      logic [CLR_W-1:0]  foreground;
      logic [CLR_W-1:0]  background;
   } cfg_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_WRAP,
      CMD_CUR_SELF,
      CMD_BS,
      CMD_TAB,
      CMD_LF,
      CMD_CR,
      CMD_TARGET,
      CMD_SET_STATUS,
      CMD_SCROLL_ONE,
      CMD_SCROLL_REQ,
      CMD_SCROLL_TOTAL,
      CMD_COPY_READ,
      CMD_COPY_WRITE,
      CMD_BLANK_WRITE,
      CMD_SCROLL_END,
      CMD_ADDR_CURSOR,
      CMD_ADDR_TARGET,
      CMD_WRITE_CHAR,
      CMD_READ_ISSUE,
      CMD_CAPTURE,
      CMD_CLEAR_START,
      CMD_CLEAR_WRITE,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
      logic       tgt_bad;
      logic       lf_scroll;
      logic       print_scroll;
      logic       copy_done;
      logic       blank_done;
      logic       clear_last;
      logic       out_free;
   } dp_stat_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_PRINT,
      S_SCROLL2,
      S_COPY_RD,
      S_COPY_WR,
      S_BLANK,
      S_ADDR,
      S_WRITE,
      S_READ,
      S_READ_CAP,
      S_FF_CLEAR,
      S_RESULT
   } state_type;

endpackage

// File: design/tcce_req_if.sv
`timescale 1ns / 1ps
// Request channel of the text console engine: valid/ready and one command beat.
// No dependencies.
interface tcce_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] character;
   logic [7:0] target_line;
   logic [7:0] target_column;
   logic [7:0] scroll_lines;

   modport source (output valid, operation, character, target_line, target_column,
                   scroll_lines, input ready);
   modport sink   (input valid, operation, character, target_line, target_column,
                   scroll_lines, output ready);
endinterface

// File: design/tcce_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the text console engine: valid/ready and one result beat.
// No dependencies.
interface tcce_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [4:0]  cursor_line;
   logic [6:0]  cursor_column;
   logic [11:0] hw_cursor_position;
   logic [15:0] read_cell;

   modport source (output valid, status, cursor_line, cursor_column, hw_cursor_position,
                   read_cell, input ready);
   modport sink   (input valid, status, cursor_line, cursor_column, hw_cursor_position,
                   read_cell, output ready);
endinterface

// File: design/tcce_dp.sv
`timescale 1ns / 1ps
// Datapath: cell store, cursor registers, scroll/clear counters, result register.
// Depends on tcce_pkg; driven by tcce_ctrl commands.
module tcce_dp #(
   parameter int MaxColumns = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MaxLines   = tcce_pkg::MAX_LINES_DEF,
   parameter int TabStop    = tcce_pkg::TAB_STOP_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcce_pkg::cfg_type                     cfg,
   input  tcce_pkg::dp_cmd_type                  cmd,
   output tcce_pkg::dp_stat_type                 stat,
   input  logic [1:0]                            req_operation,
   input  logic [7:0]                            req_character,
   input  logic [7:0]                            req_target_line,
   input  logic [7:0]                            req_target_column,
   input  logic [7:0]                            req_scroll_lines,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_status,
   output logic [tcce_pkg::LINE_W-1:0]           rsp_cursor_line,
   output logic [tcce_pkg::COL_W-1:0]            rsp_cursor_column,
   output logic [tcce_pkg::HW_W-1:0]             rsp_hw_cursor_position,
   output logic [tcce_pkg::CELL_W-1:0]           rsp_read_cell
);

   localparam int Depth    = MaxColumns * MaxLines;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW     = $clog2(Depth + 1);
   localparam int TabRecip = (1 << 16) / TabStop;
   localparam int LW       = tcce_pkg::LINE_W;
   localparam int CW       = tcce_pkg::COL_W;

   logic [tcce_pkg::CELL_W-1:0] mem [Depth];

   logic [1:0]    op_ff, op_in;
   logic [7:0]    ch_ff, ch_in, tl_ff, tl_in, tc_ff, tc_in, sl_ff, sl_in;
   logic [LW-1:0] line_ff, line_in;
   logic [CW-1:0] col_ff, col_in;
   logic [tcce_pkg::HW_W-1:0] hw_ff, hw_in;
   logic          status_ff, status_in;
   logic [tcce_pkg::CELL_W-1:0] cell_ff, cell_in, rdata_ff;
   logic [LW-1:0] n_ff, n_in;
   logic [CntW-1:0] off_ff, off_in, total_ff, total_in, dst_ff, dst_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_status_ff, out_status_in;
   logic [LW-1:0] out_line_ff, out_line_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [tcce_pkg::HW_W-1:0] out_hw_ff, out_hw_in;
   logic [tcce_pkg::CELL_W-1:0] out_cell_ff, out_cell_in;

   logic [CW-1:0] cols;
   logic [LW-1:0] lines;
   logic [LW:0]   cand_line;
   logic [CW:0]   cand_col;
   logic          place_en, place_ok;
   logic [LW+CW:0] place_prod;
   logic [31:0]   tab_prod;
   logic [CW-1:0] tab_q, tab_r, tab_next;
   logic          tab_far;
   logic [LW-1:0] n_sel;
   logic [CntW:0] copy_src;
   logic          we, re;
   logic [AddrW-1:0] waddr, raddr;
   logic [tcce_pkg::CELL_W-1:0] wdata;
   logic [tcce_pkg::CELL_W-1:0] char_cell, blank_cell;
   logic          out_free;

   always_comb begin
      cols = cfg.column_count;
      if (cfg.column_count == '0) cols = CW'(1);
      else if (int'(cfg.column_count) > MaxColumns) cols = CW'(MaxColumns);
      lines = cfg.line_count;
      if (cfg.line_count == '0) lines = LW'(1);
      else if (int'(cfg.line_count) > MaxLines) lines = LW'(MaxLines);
   end

   always_comb begin
      tab_prod = 32'(col_ff) * 32'(TabRecip);
      tab_q    = CW'(tab_prod >> 16);
      tab_r    = CW'(32'(col_ff) - 32'(tab_q) * 32'(TabStop));
      if (32'(tab_r) >= 32'(TabStop)) tab_q = tab_q + CW'(1);
      tab_next = CW'((32'(tab_q) + 32'd1) * 32'(TabStop));
      tab_far  = (int'(col_ff) + TabStop) < (int'(cols) - 1);
   end

   assign char_cell  = {cfg.background, cfg.foreground, ch_ff};
   assign blank_cell = {cfg.background, cfg.foreground, tcce_pkg::CH_SPACE};
   assign copy_src   = {1'b0, dst_ff} + {1'b0, off_ff};
   assign out_free   = !out_valid_ff || rsp_ready;
   assign n_sel      = (cmd == tcce_pkg::CMD_SCROLL_ONE) ? LW'(1) :
                       ((sl_ff >= 8'(lines)) ? lines : LW'(sl_ff));

   always_comb begin
      place_en  = 1'b0;
      cand_line = {1'b0, line_ff};
      cand_col  = {1'b0, col_ff};
      case (cmd)
         tcce_pkg::CMD_WRAP: begin
            place_en  = col_ff >= cols;
            cand_line = {1'b0, line_ff} + (LW+1)'(1);
            cand_col  = '0;
         end
         tcce_pkg::CMD_CUR_SELF: begin
            place_en = 1'b1;
         end
         tcce_pkg::CMD_BS: begin
            if (col_ff != '0) begin
               place_en = 1'b1;
               cand_col = {1'b0, col_ff} - (CW+1)'(1);
            end else if (line_ff != '0) begin
               place_en  = 1'b1;
               cand_line = {1'b0, line_ff} - (LW+1)'(1);
               cand_col  = {1'b0, cols} - (CW+1)'(1);
            end
         end
         tcce_pkg::CMD_TAB: begin
            place_en = 1'b1;
            cand_col = tab_far ? {1'b0, tab_next} : ({1'b0, cols} - (CW+1)'(1));
         end
         tcce_pkg::CMD_LF: begin
            place_en  = 1'b1;
            cand_line = {1'b0, line_ff} + (LW+1)'(1);
            cand_col  = '0;
         end
         tcce_pkg::CMD_CR: begin
            place_en = 1'b1;
            cand_col = '0;
         end
         tcce_pkg::CMD_TARGET: begin
            place_en  = 1'b1;
            cand_line = tl_ff[LW:0];
            cand_col  = tc_ff[CW:0];
         end
         tcce_pkg::CMD_SCROLL_END: begin
            place_en  = 1'b1;
            cand_line = {1'b0, lines} - {1'b0, n_ff};
            cand_col  = '0;
         end
         default: begin
            place_en = 1'b0;
         end
      endcase
      place_ok   = place_en && (cand_line <= {1'b0, lines}) && (cand_col <= {1'b0, cols});
      place_prod = cand_line * cols;
   end

   always_comb begin
      op_in = op_ff; ch_in = ch_ff; tl_in = tl_ff; tc_in = tc_ff; sl_in = sl_ff;
      line_in = line_ff; col_in = col_ff; hw_in = hw_ff;
      status_in = status_ff; cell_in = cell_ff;
      n_in = n_ff; off_in = off_ff; total_in = total_ff; dst_in = dst_ff;
      addr_in = addr_ff;
      out_status_in = out_status_ff; out_line_in = out_line_ff; out_col_in = out_col_ff;
      out_hw_in = out_hw_ff; out_cell_in = out_cell_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      we = 1'b0; re = 1'b0;
      waddr = dst_ff[AddrW-1:0]; raddr = addr_ff; wdata = '0;
      if (place_ok) begin
         line_in = cand_line[LW-1:0];
         col_in  = cand_col[CW-1:0];
         hw_in   = tcce_pkg::HW_W'(place_prod) + tcce_pkg::HW_W'(cand_col);
      end
      case (cmd)
         tcce_pkg::CMD_LOAD: begin
            op_in = req_operation; ch_in = req_character; tl_in = req_target_line;
            tc_in = req_target_column; sl_in = req_scroll_lines;
            status_in = 1'b0; cell_in = '0;
         end
         tcce_pkg::CMD_SET_STATUS: status_in = 1'b1;
         tcce_pkg::CMD_SCROLL_ONE, tcce_pkg::CMD_SCROLL_REQ: begin
            n_in   = n_sel;
            off_in = CntW'(n_sel * cols);
         end
         tcce_pkg::CMD_SCROLL_TOTAL: begin
            total_in = CntW'(lines * cols);
            dst_in   = '0;
         end
         tcce_pkg::CMD_COPY_READ: begin
            re    = 1'b1;
            raddr = copy_src[AddrW-1:0];
         end
         tcce_pkg::CMD_COPY_WRITE: begin
            we     = 1'b1;
            wdata  = rdata_ff;
            dst_in = dst_ff + CntW'(1);
         end
         tcce_pkg::CMD_BLANK_WRITE: begin
            we     = 1'b1;
            wdata  = blank_cell;
            dst_in = dst_ff + CntW'(1);
         end
         tcce_pkg::CMD_ADDR_CURSOR: addr_in = AddrW'(line_ff * cols) + AddrW'(col_ff);
         tcce_pkg::CMD_ADDR_TARGET:
            addr_in = AddrW'(tl_ff[LW-1:0] * cols) + AddrW'(tc_ff[CW-1:0]);
         tcce_pkg::CMD_WRITE_CHAR: begin
            we     = 1'b1;
            waddr  = addr_ff;
            wdata  = char_cell;
            col_in = col_ff + CW'(1);
         end
         tcce_pkg::CMD_READ_ISSUE: re = 1'b1;
         tcce_pkg::CMD_CAPTURE:    cell_in = rdata_ff;
         tcce_pkg::CMD_CLEAR_START: dst_in = '0;
         tcce_pkg::CMD_CLEAR_WRITE: begin
            we     = 1'b1;
            wdata  = '0;
            dst_in = dst_ff + CntW'(1);
         end
         tcce_pkg::CMD_EMIT: begin
            out_valid_in  = 1'b1;
            out_status_in = status_ff;
            out_line_in   = line_ff;
            out_col_in    = col_ff;
            out_hw_in     = hw_ff;
            out_cell_in   = cell_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         col_ff       <= '0;
         hw_ff        <= '0;
         dst_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         line_ff      <= line_in;
         col_ff       <= col_in;
         hw_ff        <= hw_in;
         dst_ff       <= dst_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; ch_ff <= ch_in; tl_ff <= tl_in; tc_ff <= tc_in; sl_ff <= sl_in;
      status_ff <= status_in; cell_ff <= cell_in;
      n_ff <= n_in; off_ff <= off_in; total_ff <= total_in; addr_ff <= addr_in;
      out_status_ff <= out_status_in; out_line_ff <= out_line_in; out_col_ff <= out_col_in;
      out_hw_ff <= out_hw_in; out_cell_ff <= out_cell_in;
   end

   always_comb begin
      stat.op           = op_ff;
      stat.ch           = ch_ff;
      stat.tgt_bad      = (tl_ff >= 8'(lines)) || (tc_ff >= 8'(cols));
      stat.lf_scroll    = ({1'b0, line_ff} + (LW+1)'(1)) >= {1'b0, lines};
      stat.print_scroll = line_ff >= lines;
      stat.copy_done    = copy_src >= {1'b0, total_ff};
      stat.blank_done   = dst_ff >= total_ff;
      stat.clear_last   = dst_ff == CntW'(Depth - 1);
      stat.out_free     = out_free;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = out_status_ff;
   assign rsp_cursor_line        = out_line_ff;
   assign rsp_cursor_column      = out_col_ff;
   assign rsp_hw_cursor_position = out_hw_ff;
   assign rsp_read_cell          = out_cell_ff;

endmodule

// File: design/tcce_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences datapath commands per request beat.
// Depends on tcce_pkg.
module tcce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcce_pkg::dp_stat_type stat,
   output tcce_pkg::dp_cmd_type  cmd
);

   tcce_pkg::state_type state_ff, state_in;
   logic ret_ff, ret_in;   // 1: scroll returns into the character write

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         tcce_pkg::S_INIT: if (stat.clear_last) state_in = tcce_pkg::S_IDLE;
         tcce_pkg::S_IDLE: if (req_valid) state_in = tcce_pkg::S_DECODE;
         tcce_pkg::S_DECODE: begin
            state_in = tcce_pkg::S_RESULT;
            ret_in   = 1'b0;
            case (stat.op)
               tcce_pkg::OP_CHAR: begin
                  if (stat.ch inside {[tcce_pkg::CH_PRINT_LO:tcce_pkg::CH_PRINT_HI]})
                     state_in = tcce_pkg::S_PRINT;
                  else if (stat.ch == tcce_pkg::CH_LF && stat.lf_scroll)
                     state_in = tcce_pkg::S_SCROLL2;
                  else if (stat.ch == tcce_pkg::CH_FF)
                     state_in = tcce_pkg::S_FF_CLEAR;
               end
               tcce_pkg::OP_READ: if (!stat.tgt_bad) state_in = tcce_pkg::S_READ;
               tcce_pkg::OP_SCROLL: state_in = tcce_pkg::S_SCROLL2;
               default: state_in = tcce_pkg::S_RESULT;
            endcase
         end
         tcce_pkg::S_PRINT: begin
            if (stat.print_scroll) begin
               state_in = tcce_pkg::S_SCROLL2;
               ret_in   = 1'b1;
            end else begin
               state_in = tcce_pkg::S_ADDR;
            end
         end
         tcce_pkg::S_SCROLL2: state_in = tcce_pkg::S_COPY_RD;
         tcce_pkg::S_COPY_RD:
            state_in = stat.copy_done ? tcce_pkg::S_BLANK : tcce_pkg::S_COPY_WR;
         tcce_pkg::S_COPY_WR: state_in = tcce_pkg::S_COPY_RD;
         tcce_pkg::S_BLANK:
            if (stat.blank_done) state_in = ret_ff ? tcce_pkg::S_ADDR : tcce_pkg::S_RESULT;
         tcce_pkg::S_ADDR:     state_in = tcce_pkg::S_WRITE;
         tcce_pkg::S_WRITE:    state_in = tcce_pkg::S_RESULT;
         tcce_pkg::S_READ:     state_in = tcce_pkg::S_READ_CAP;
         tcce_pkg::S_READ_CAP: state_in = tcce_pkg::S_RESULT;
         tcce_pkg::S_FF_CLEAR: if (stat.clear_last) state_in = tcce_pkg::S_RESULT;
         tcce_pkg::S_RESULT:   if (stat.out_free) state_in = tcce_pkg::S_IDLE;
         default: state_in = tcce_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = tcce_pkg::CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         tcce_pkg::S_INIT: cmd = tcce_pkg::CMD_CLEAR_WRITE;
         tcce_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = tcce_pkg::CMD_LOAD;
         end
         tcce_pkg::S_DECODE: begin
            case (stat.op)
               tcce_pkg::OP_CHAR: begin
                  if (stat.ch inside {[tcce_pkg::CH_PRINT_LO:tcce_pkg::CH_PRINT_HI]})
                     cmd = tcce_pkg::CMD_WRAP;
                  else begin
                     case (stat.ch)
                        tcce_pkg::CH_BS:  cmd = tcce_pkg::CMD_BS;
                        tcce_pkg::CH_TAB: cmd = tcce_pkg::CMD_TAB;
                        tcce_pkg::CH_LF:
                           cmd = stat.lf_scroll ? tcce_pkg::CMD_SCROLL_ONE : tcce_pkg::CMD_LF;
                        tcce_pkg::CH_FF:  cmd = tcce_pkg::CMD_CLEAR_START;
                        tcce_pkg::CH_CR:  cmd = tcce_pkg::CMD_CR;
                        default:          cmd = tcce_pkg::CMD_NONE;
                     endcase
                  end
               end
               tcce_pkg::OP_READ:
                  cmd = stat.tgt_bad ? tcce_pkg::CMD_SET_STATUS : tcce_pkg::CMD_ADDR_TARGET;
               tcce_pkg::OP_SET:
                  cmd = stat.tgt_bad ? tcce_pkg::CMD_SET_STATUS : tcce_pkg::CMD_TARGET;
               default: cmd = tcce_pkg::CMD_SCROLL_REQ;
            endcase
         end
         tcce_pkg::S_PRINT:
            cmd = stat.print_scroll ? tcce_pkg::CMD_SCROLL_ONE : tcce_pkg::CMD_CUR_SELF;
         tcce_pkg::S_SCROLL2: cmd = tcce_pkg::CMD_SCROLL_TOTAL;
         tcce_pkg::S_COPY_RD: if (!stat.copy_done) cmd = tcce_pkg::CMD_COPY_READ;
         tcce_pkg::S_COPY_WR: cmd = tcce_pkg::CMD_COPY_WRITE;
         tcce_pkg::S_BLANK:
            cmd = stat.blank_done ? tcce_pkg::CMD_SCROLL_END : tcce_pkg::CMD_BLANK_WRITE;
         tcce_pkg::S_ADDR:     cmd = tcce_pkg::CMD_ADDR_CURSOR;
         tcce_pkg::S_WRITE:    cmd = tcce_pkg::CMD_WRITE_CHAR;
         tcce_pkg::S_READ:     cmd = tcce_pkg::CMD_READ_ISSUE;
         tcce_pkg::S_READ_CAP: cmd = tcce_pkg::CMD_CAPTURE;
         tcce_pkg::S_FF_CLEAR: cmd = tcce_pkg::CMD_CLEAR_WRITE;
         tcce_pkg::S_RESULT:   if (stat.out_free) cmd = tcce_pkg::CMD_EMIT;
         default: cmd = tcce_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcce_pkg::S_INIT;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

// File: design/text_console_char_engine.sv
`timescale 1ns / 1ps
// Top level of the text console character engine: CSR block, controller, datapath.
// Depends on tcce_pkg, tcce_req_if, tcce_rsp_if, tcce_ctrl, tcce_dp.
//
// Usage:
//   req_ch carries one command beat (process character, read cell, set cursor,
//   scroll); rsp_ch returns exactly one result beat per command, in order.
//   The csr_ APB port writes column count, line count and colors at 4*index;
//   write only while the engine is idle. pready is always high.
// The cell store is walked by scroll and by a line feed past the bottom: each moved
//   cell is read and then written, then each blanked cell is written; a printable
//   byte past the bottom scrolls by one line before its write. Form feed clears
//   the whole store to zero.
// One command is worked at a time; the next beat is taken the cycle after the
//   result is in the output register, even while that result waits on
//   rsp_ch.ready. A new result waits in the controller while the previous one
//   is still stalled.
// After reset every cell of the store is swept to zero with req_ch.ready low;
//   CSR writes are taken throughout.
module text_console_char_engine #(
   parameter int MaxColumns = tcce_pkg::MAX_COLUMNS_DEF,
   parameter int MaxLines   = tcce_pkg::MAX_LINES_DEF,
   parameter int TabStop    = tcce_pkg::TAB_STOP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   tcce_req_if.sink                      req_ch,
   tcce_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tcce_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tcce_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tcce_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   tcce_pkg::cfg_type     cfg_ff, cfg_in;
   tcce_pkg::dp_cmd_type  cmd;
   tcce_pkg::dp_stat_type stat;
   logic [1:0]            csr_index;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            tcce_pkg::REG_COLUMN_COUNT:
               cfg_in.column_count = csr_pwdata[tcce_pkg::COL_W-1:0];
            tcce_pkg::REG_LINE_COUNT:
               cfg_in.line_count = csr_pwdata[tcce_pkg::LINE_W-1:0];
            tcce_pkg::REG_FOREGROUND:
               cfg_in.foreground = csr_pwdata[tcce_pkg::CLR_W-1:0];
            tcce_pkg::REG_BACKGROUND:
               cfg_in.background = csr_pwdata[tcce_pkg::CLR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tcce_pkg::REG_COLUMN_COUNT: csr_prdata = tcce_pkg::CSR_DW'(cfg_ff.column_count);
         tcce_pkg::REG_LINE_COUNT:   csr_prdata = tcce_pkg::CSR_DW'(cfg_ff.line_count);
         tcce_pkg::REG_FOREGROUND:   csr_prdata = tcce_pkg::CSR_DW'(cfg_ff.foreground);
         tcce_pkg::REG_BACKGROUND:   csr_prdata = tcce_pkg::CSR_DW'(cfg_ff.background);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count <= tcce_pkg::COLUMN_COUNT_RST;
         cfg_ff.line_count   <= tcce_pkg::LINE_COUNT_RST;
         cfg_ff.foreground   <= tcce_pkg::FOREGROUND_RST;
         cfg_ff.background   <= tcce_pkg::BACKGROUND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tcce_dp #(
      .MaxColumns (MaxColumns),
      .MaxLines   (MaxLines),
      .TabStop    (TabStop)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_operation          (req_ch.operation),
      .req_character          (req_ch.character),
      .req_target_line        (req_ch.target_line),
      .req_target_column      (req_ch.target_column),
      .req_scroll_lines       (req_ch.scroll_lines),
      .rsp_valid              (rsp_ch.valid),
      .rsp_ready              (rsp_ch.ready),
      .rsp_status             (rsp_ch.status),
      .rsp_cursor_line        (rsp_ch.cursor_line),
      .rsp_cursor_column      (rsp_ch.cursor_column),
      .rsp_hw_cursor_position (rsp_ch.hw_cursor_position),
      .rsp_read_cell          (rsp_ch.read_cell)
   );

endmodule

// File: tb/tb_channels.sv
`timescale 1ns / 1ps
// Testbench helpers for the text console engine channels: command and result beats.
// No dependencies; the channel interfaces come from the design folder.
package tb_console_pkg;

   typedef struct {
      logic [1:0] operation;
      logic [7:0] character;
      logic [7:0] target_line;
      logic [7:0] target_column;
      logic [7:0] scroll_lines;
   } console_cmd_type;

   typedef struct {
      logic        status;
      logic [4:0]  cursor_line;
      logic [6:0]  cursor_column;
      logic [11:0] hw_cursor_position;
      logic [15:0] read_cell;
   } console_result_type;
endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of text_console_char_engine: directed commands, then random
// bursts over a sweep of screen shapes; a behavioral screen model predicts every result
// beat. Depends on tcce_pkg, tb_console_pkg, tcce_req_if, tcce_rsp_if and the engine RTL.
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [tcce_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [tcce_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [tcce_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   tcce_req_if req_ch ();
   tcce_rsp_if rsp_ch ();

   text_console_char_engine uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // screen model
   logic [15:0] screen [0:1999];
   int unsigned cur_ln, cur_col, hw_pos;
   int unsigned reg_cols = 80, reg_lines = 25, reg_fg = 15, reg_bg = 0;

   tb_console_pkg::console_cmd_type    pending_cmds[$];
   tb_console_pkg::console_result_type expected_results[$];
   int errors = 0;
   bit stim_done = 0;
   int burst_left = 0, gap_left = 0;
   int unsigned stall_phase = 0;

   function automatic int unsigned cols_in_use();
      if (reg_cols == 0) return 1;
      if (reg_cols > 80) return 80;
      return reg_cols;
   endfunction

   function automatic int unsigned lines_in_use();
      if (reg_lines == 0) return 1;
      if (reg_lines > 25) return 25;
      return reg_lines;
   endfunction

   function automatic void move_cursor(int unsigned ln, int unsigned col);
      if (ln > lines_in_use() || col > cols_in_use()) return;
      cur_ln = ln;
      cur_col = col;
      hw_pos = (col + ln * cols_in_use()) & 12'hFFF;
   endfunction

   function automatic void write_cell(int unsigned ln, int unsigned col, logic [7:0] ch);
      if (ln >= lines_in_use() || col >= cols_in_use()) return;
      screen[ln * cols_in_use() + col] = {reg_bg[3:0], reg_fg[3:0], ch};
   endfunction

   function automatic void scroll_screen(int unsigned n);
      int unsigned lines, cols;
      lines = lines_in_use();
      cols = cols_in_use();
      if (n > lines) n = lines;
      if (n > 0 && n < lines)
         for (int i = 0; i < (lines - n) * cols; i++) screen[i] = screen[i + n * cols];
      for (int r = lines - n; r < lines; r++)
         for (int c = 0; c < cols; c++) write_cell(r, c, tcce_pkg::CH_SPACE);
      move_cursor(lines - n, 0);
   endfunction

   function automatic void console_byte(logic [7:0] ch);
      int unsigned cols, lines;
      cols = cols_in_use();
      lines = lines_in_use();
      if (ch >= tcce_pkg::CH_PRINT_LO && ch <= tcce_pkg::CH_PRINT_HI) begin
         if (cur_col > cols - 1) move_cursor(cur_ln + 1, 0);
         if (cur_ln >= lines) scroll_screen(1);
         else move_cursor(cur_ln, cur_col);
         write_cell(cur_ln, cur_col, ch);
         cur_col++;
      end else if (ch == tcce_pkg::CH_BS) begin
         if (cur_col > 0) move_cursor(cur_ln, cur_col - 1);
         else if (cur_ln > 0) move_cursor(cur_ln - 1, cols - 1);
      end else if (ch == tcce_pkg::CH_TAB) begin
         if (int'(cur_col) + 8 < int'(cols) - 1) move_cursor(cur_ln, cur_col + (8 - cur_col % 8));
         else move_cursor(cur_ln, cols - 1);
      end else if (ch == tcce_pkg::CH_LF) begin
         if (cur_ln < lines - 1) move_cursor(cur_ln + 1, 0);
         else scroll_screen(1);
      end else if (ch == tcce_pkg::CH_FF) begin
         foreach (screen[i]) screen[i] = '0;
      end else if (ch == tcce_pkg::CH_CR) begin
         move_cursor(cur_ln, 0);
      end
   endfunction

   function automatic tb_console_pkg::console_result_type predict_result(
      tb_console_pkg::console_cmd_type cmd);
      tb_console_pkg::console_result_type res;
      res.status = 1'b0;
      res.read_cell = '0;
      case (cmd.operation)
         tcce_pkg::OP_CHAR: console_byte(cmd.character);
         tcce_pkg::OP_READ: begin
            if (cmd.target_line >= lines_in_use() || cmd.target_column >= cols_in_use())
               res.status = 1'b1;
            else
               res.read_cell = screen[cmd.target_line * cols_in_use() + cmd.target_column];
         end
         tcce_pkg::OP_SET: begin
            if (cmd.target_line >= lines_in_use() || cmd.target_column >= cols_in_use())
               res.status = 1'b1;
            else
               move_cursor(cmd.target_line, cmd.target_column);
         end
         default: scroll_screen(cmd.scroll_lines);
      endcase
      res.cursor_line = cur_ln[4:0];
      res.cursor_column = cur_col[6:0];
      res.hw_cursor_position = hw_pos[11:0];
      return res;
   endfunction

   // driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.character = '0;
      req_ch.target_line = '0;
      req_ch.target_column = '0;
      req_ch.scroll_lines = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            tb_console_pkg::console_cmd_type acc;
            acc.operation = req_ch.operation;
            acc.character = req_ch.character;
            acc.target_line = req_ch.target_line;
            acc.target_column = req_ch.target_column;
            acc.scroll_lines = req_ch.scroll_lines;
            expected_results.push_back(predict_result(acc));
            void'(pending_cmds.pop_front());
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (gap_left > 0) gap_left--;
            if (pending_cmds.size() != 0 && gap_left == 0) begin
               req_ch.valid <= 1'b1;
               req_ch.operation <= pending_cmds[0].operation;
               req_ch.character <= pending_cmds[0].character;
               req_ch.target_line <= pending_cmds[0].target_line;
               req_ch.target_column <= pending_cmds[0].target_column;
               req_ch.scroll_lines <= pending_cmds[0].scroll_lines;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(12, 0);
                  gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with none expected, actual %0d/%0d/%0d/%0d/%h",
                        $realtime, rsp_ch.status, rsp_ch.cursor_line, rsp_ch.cursor_column,
                        rsp_ch.hw_cursor_position, rsp_ch.read_cell);
               errors++;
            end else begin
               tb_console_pkg::console_result_type exp_res;
               exp_res = expected_results.pop_front();
               if (rsp_ch.status !== exp_res.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           exp_res.status, rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.cursor_line !== exp_res.cursor_line) begin
                  $display("%0t: cursor_line expected %0d actual %0d", $realtime,
                           exp_res.cursor_line, rsp_ch.cursor_line);
                  errors++;
               end
               if (rsp_ch.cursor_column !== exp_res.cursor_column) begin
                  $display("%0t: cursor_column expected %0d actual %0d", $realtime,
                           exp_res.cursor_column, rsp_ch.cursor_column);
                  errors++;
               end
               if (rsp_ch.hw_cursor_position !== exp_res.hw_cursor_position) begin
                  $display("%0t: hw_cursor_position expected %0d actual %0d", $realtime,
                           exp_res.hw_cursor_position, rsp_ch.hw_cursor_position);
                  errors++;
               end
               if (rsp_ch.read_cell !== exp_res.read_cell) begin
                  $display("%0t: read_cell expected %h actual %h", $realtime,
                           exp_res.read_cell, rsp_ch.read_cell);
                  errors++;
               end
            end
         end
         stall_phase++;
         if (stall_phase % 64 < 24) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(3, 0) != 0);
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= tcce_pkg::CSR_AW'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         tcce_pkg::REG_COLUMN_COUNT: reg_cols = value[6:0];
         tcce_pkg::REG_LINE_COUNT: reg_lines = value[4:0];
         tcce_pkg::REG_FOREGROUND: reg_fg = value[3:0];
         default: reg_bg = value[3:0];
      endcase
   endtask

   task automatic add_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] ln, logic [7:0] col,
                          logic [7:0] sl);
      tb_console_pkg::console_cmd_type cmd;
      cmd.operation = op;
      cmd.character = ch;
      cmd.target_line = ln;
      cmd.target_column = col;
      cmd.scroll_lines = sl;
      pending_cmds.push_back(cmd);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_results.size() != 0 || req_ch.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // mostly well-formed text: printable runs with control bytes, some ops
   task automatic add_random(int count);
      int unsigned pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         if (pick < 55)
            add_cmd(tcce_pkg::OP_CHAR, 8'($urandom_range(126, 32)), 8'($urandom),
                    8'($urandom), 8'($urandom));
         else if (pick < 68) begin
            case ($urandom_range(5, 0))
               0: add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_BS, 8'($urandom), 8'($urandom),
                          8'($urandom));
               1: add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_TAB, 8'($urandom), 8'($urandom),
                          8'($urandom));
               2: add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_LF, 8'($urandom), 8'($urandom),
                          8'($urandom));
               3: add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_CR, 8'($urandom), 8'($urandom),
                          8'($urandom));
               4: add_cmd(tcce_pkg::OP_CHAR,
                          ($urandom_range(40, 0) == 0) ? tcce_pkg::CH_FF : tcce_pkg::CH_LF,
                          8'($urandom), 8'($urandom), 8'($urandom));
               default: add_cmd(tcce_pkg::OP_CHAR, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom));
            endcase
         end else if (pick < 82)
            add_cmd(tcce_pkg::OP_READ, 8'($urandom), 8'($urandom_range(pick[0] ? 255 : 26, 0)),
                    8'($urandom_range(pick[1] ? 255 : 81, 0)), 8'($urandom));
         else if (pick < 94)
            add_cmd(tcce_pkg::OP_SET, 8'($urandom), 8'($urandom_range(pick[0] ? 255 : 26, 0)),
                    8'($urandom_range(pick[1] ? 255 : 81, 0)), 8'($urandom));
         else
            add_cmd(tcce_pkg::OP_SCROLL, 8'($urandom), 8'($urandom), 8'($urandom),
                    pick[0] ? 8'($urandom) : 8'($urandom_range(4, 0)));
      end
   endtask

   initial begin
      foreach (screen[i]) screen[i] = '0;
      cur_ln = 0;
      cur_col = 0;
      hw_pos = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed
      add_cmd(tcce_pkg::OP_READ, 8'h00, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_BS, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_PRINT_LO, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_PRINT_HI, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, 8'd127, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, 8'hFF, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_TAB, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_READ, 8'h00, 8'd0, 8'd1, 8'd0);
      add_cmd(tcce_pkg::OP_SET, 8'h00, 8'd24, 8'd79, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, 8'h41, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, 8'h42, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_TAB, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_LF, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_CR, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_BS, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_SET, 8'h00, 8'd25, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_SET, 8'h00, 8'd0, 8'd80, 8'd0);
      add_cmd(tcce_pkg::OP_READ, 8'h00, 8'd255, 8'd255, 8'd0);
      add_cmd(tcce_pkg::OP_READ, 8'h00, 8'd23, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_SCROLL, 8'h00, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_SCROLL, 8'h00, 8'd0, 8'd0, 8'd3);
      add_cmd(tcce_pkg::OP_SCROLL, 8'h00, 8'd0, 8'd0, 8'd255);
      add_cmd(tcce_pkg::OP_CHAR, tcce_pkg::CH_FF, 8'd0, 8'd0, 8'd0);
      add_cmd(tcce_pkg::OP_READ, 8'h00, 8'd24, 8'd0, 8'd0);
      wait_drained();

      // sweep of screen shapes and colors, extremes included
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, 32'd0);
               csr_write(tcce_pkg::REG_LINE_COUNT, 32'd0);
            end
            1: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, 32'd127);
               csr_write(tcce_pkg::REG_LINE_COUNT, 32'd31);
            end
            2: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, 32'd1);
               csr_write(tcce_pkg::REG_LINE_COUNT, 32'd2);
            end
            3: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, 32'd10);
               csr_write(tcce_pkg::REG_LINE_COUNT, 32'd4);
            end
            4: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, 32'd80);
               csr_write(tcce_pkg::REG_LINE_COUNT, 32'd25);
            end
            default: begin
               csr_write(tcce_pkg::REG_COLUMN_COUNT, $urandom_range(20, 2));
               csr_write(tcce_pkg::REG_LINE_COUNT, $urandom_range(6, 1));
            end
         endcase
         csr_write(tcce_pkg::REG_FOREGROUND, (phase == 0) ? 32'd0 : $urandom);
         csr_write(tcce_pkg::REG_BACKGROUND, (phase == 1) ? 32'd15 : $urandom);
         add_cmd(tcce_pkg::OP_SET, 8'h00, 8'd0, 8'd0, 8'd0);
         add_random(phase == 4 ? 60 : 137);
         wait_drained();
      end
      stim_done = 1;
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #300ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
